### sv/rdp_pkg.sv
// Shared types, constants and helpers for the relative date parser.
package rdp_pkg;

	// Character codes
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_Y     = 8'h79;
	localparam logic [7:0] CH_M     = 8'h6D;
	localparam logic [7:0] CH_D     = 8'h64;

	// Range limits and packing factors
	localparam int unsigned MONTH_MAX = 11;
	localparam int unsigned DAY_MAX   = 30;
	localparam int unsigned MONTHS_PER_YEAR = MONTH_MAX + 1;
	localparam int unsigned DAYS_PER_MONTH  = DAY_MAX + 1;

	// Token queue between front and back
	localparam int unsigned QUEUE_DEPTH = 4;

	// Unit positions, in the order they may appear
	typedef enum logic [1:0] {
		UNIT_Y = 2'd0,
		UNIT_M = 2'd1,
		UNIT_D = 2'd2
	} unit_t;

	// Character classes
	typedef enum logic [1:0] {
		TK_SPACE = 2'd0,
		TK_DIGIT = 2'd1,
		TK_UNIT  = 2'd2,
		TK_OTHER = 2'd3
	} kind_t;

	// One classified character
	typedef struct packed {
		kind_t       kind;
		logic [3:0]  digit;
		unit_t       unit;
		logic        last;
	} token_t;

	// Bits needed for a number of n decimal digits
	function automatic int unsigned digits_to_bits(input int unsigned n);
		int unsigned p;
		p = 1;
		for (int unsigned i = 0; i < n; i++) begin
			p = p * 10;
		end
		return $clog2(p);
	endfunction

endpackage

### sv/rdp_front.sv
// Front end: accepts characters, classifies them and hands tokens to the queue.
module rdp_front import rdp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] ch,
	input  logic       last,
	input  logic       item_valid,
	output logic       item_ready,
	output token_t     tok,
	output logic       tok_valid,
	input  logic       tok_ready
);

	token_t tok_s1;
	logic   tok_v_s1;
	token_t cls;

	// Classify the incoming character
	always_comb begin
		cls.kind  = TK_OTHER;
		cls.digit = 4'(ch - CH_ZERO);
		cls.unit  = UNIT_Y;
		cls.last  = last;
		if ((ch >= CH_TAB && ch <= CH_CR) || ch == CH_SPACE) begin
			cls.kind = TK_SPACE;
		end else if (ch >= CH_ZERO && ch <= CH_NINE) begin
			cls.kind = TK_DIGIT;
		end else if (ch == CH_Y) begin
			cls.kind = TK_UNIT;
			cls.unit = UNIT_Y;
		end else if (ch == CH_M) begin
			cls.kind = TK_UNIT;
			cls.unit = UNIT_M;
		end else if (ch == CH_D) begin
			cls.kind = TK_UNIT;
			cls.unit = UNIT_D;
		end
	end

	assign item_ready = !tok_v_s1 || tok_ready;

	// Token register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_v_s1 <= 1'b0;
		end else if (item_ready) begin
			tok_v_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			tok_s1 <= cls;
		end
	end

	assign tok       = tok_s1;
	assign tok_valid = tok_v_s1;

endmodule

### sv/rdp_queue.sv
// Short token queue decoupling the front end from the parse engine.
module rdp_queue import rdp_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  token_t wr_tok,
	input  logic   wr_valid,
	output logic   wr_ready,
	output token_t rd_tok,
	output logic   rd_valid,
	input  logic   rd_ready
);

	localparam int unsigned PW = $clog2(QUEUE_DEPTH);
	localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

	token_t          mem_q [QUEUE_DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            push;
	logic            pop;

	assign wr_ready = count_q != CW'(QUEUE_DEPTH);
	assign rd_valid = count_q != '0;
	assign rd_tok   = mem_q[rd_ptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_tok;
		end
	end

endmodule

### sv/rdp_back.sv
// Parse engine: runs the date grammar over tokens and emits the parsed fields.
module rdp_back import rdp_pkg::*; #(
	parameter int unsigned DIGITS_MAX = 4,
	parameter int unsigned AW = 14
) (
	input  logic          clk,
	input  logic          arst_n,
	input  token_t        tok,
	input  logic          tok_valid,
	output logic          tok_ready,
	output logic          pk_valid,
	input  logic          pk_ready,
	output logic          pk_status,
	output logic [AW-1:0] pk_years,
	output logic [3:0]    pk_months,
	output logic [4:0]    pk_days,
	output logic [2:0]    pk_mask
);

	localparam int unsigned NW = $clog2(DIGITS_MAX + 1);

	typedef enum logic [1:0] {
		PH_EXPECT = 2'b01,
		PH_NUMBER = 2'b10
	} phase_t;

	phase_t          phase_q, phase_d;
	logic [AW-1:0]   accum_q, accum_d;
	logic [NW-1:0]   count_q, count_d;
	unit_t           upos_q, upos_d;
	logic [AW-1:0]   year_q, year_d;
	logic [3:0]      month_q, month_d;
	logic [4:0]      day_q, day_d;
	logic [2:0]      mask_q, mask_d;
	logic            failed_q, failed_d;
	logic            unit_ok;
	logic            step;

	assign tok_ready = !tok.last || pk_ready;
	assign pk_valid  = tok_valid && tok.last;
	assign step      = tok_valid && tok_ready;

	// Grammar step for one token
	always_comb begin
		phase_d  = phase_q;
		accum_d  = accum_q;
		count_d  = count_q;
		upos_d   = upos_q;
		year_d   = year_q;
		month_d  = month_q;
		day_d    = day_q;
		mask_d   = mask_q;
		failed_d = failed_q;
		unit_ok  = 1'b0;
		if (!failed_q) begin
			case (phase_q)
				PH_EXPECT: begin
					if (tok.kind == TK_DIGIT) begin
						accum_d = AW'(tok.digit);
						count_d = NW'(1);
						phase_d = PH_NUMBER;
					end else if (tok.kind != TK_SPACE) begin
						failed_d = 1'b1;
					end
				end
				PH_NUMBER: begin
					if (tok.kind == TK_DIGIT) begin
						if (32'(count_q) >= DIGITS_MAX) begin
							failed_d = 1'b1;
						end else begin
							accum_d = accum_q * AW'(10) + AW'(tok.digit);
							count_d = count_q + 1'b1;
						end
					end else if (tok.kind == TK_UNIT && tok.unit >= upos_q) begin
						upos_d = tok.unit;
						if (tok.unit == UNIT_M && 32'(accum_q) > MONTH_MAX) begin
							failed_d = 1'b1;
						end else if (tok.unit == UNIT_D && 32'(accum_q) > DAY_MAX) begin
							failed_d = 1'b1;
						end else begin
							case (tok.unit)
								UNIT_Y: begin
									year_d = accum_q;
									mask_d = mask_q | 3'b100;
								end
								UNIT_M: begin
									month_d = 4'(accum_q);
									mask_d  = mask_q | 3'b010;
								end
								default: begin
									day_d  = 5'(accum_q);
									mask_d = mask_q | 3'b001;
								end
							endcase
							phase_d = PH_EXPECT;
							accum_d = '0;
							count_d = '0;
							unit_ok = 1'b1;
						end
					end else begin
						failed_d = 1'b1;
					end
				end
				default: failed_d = 1'b1;
			endcase
		end
	end

	// Result fields, zero on error
	always_comb begin
		pk_status = failed_d || !unit_ok;
		pk_years  = pk_status ? '0 : year_d;
		pk_months = pk_status ? '0 : month_d;
		pk_days   = pk_status ? '0 : day_d;
		pk_mask   = pk_status ? '0 : mask_d;
	end

	// Parser state; cleared after the last character of a string
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_EXPECT;
			accum_q  <= '0;
			count_q  <= '0;
			upos_q   <= UNIT_Y;
			year_q   <= '0;
			month_q  <= '0;
			day_q    <= '0;
			mask_q   <= '0;
			failed_q <= 1'b0;
		end else if (step) begin
			if (tok.last) begin
				phase_q  <= PH_EXPECT;
				accum_q  <= '0;
				count_q  <= '0;
				upos_q   <= UNIT_Y;
				year_q   <= '0;
				month_q  <= '0;
				day_q    <= '0;
				mask_q   <= '0;
				failed_q <= 1'b0;
			end else begin
				phase_q  <= phase_d;
				accum_q  <= accum_d;
				count_q  <= count_d;
				upos_q   <= upos_d;
				year_q   <= year_d;
				month_q  <= month_d;
				day_q    <= day_d;
				mask_q   <= mask_d;
				failed_q <= failed_d;
			end
		end
	end

endmodule

### sv/rdp_pack.sv
// Result packing: two-stage (years*12+months)*31+days and the output register.
module rdp_pack import rdp_pkg::*; #(
	parameter int unsigned AW = 14
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          pk_valid,
	output logic          pk_ready,
	input  logic          pk_status,
	input  logic [AW-1:0] pk_years,
	input  logic [3:0]    pk_months,
	input  logic [4:0]    pk_days,
	input  logic [2:0]    pk_mask,
	output logic          res_valid,
	input  logic          res_ready,
	output logic          status,
	output logic [13:0]   years,
	output logic [3:0]    months,
	output logic [4:0]    days,
	output logic [2:0]    unit_mask,
	output logic [21:0]   packed_res
);

	localparam int unsigned YW = AW + 4;

	logic          v_s1;
	logic          status_s1;
	logic [AW-1:0] years_s1;
	logic [3:0]    months_s1;
	logic [4:0]    days_s1;
	logic [2:0]    mask_s1;
	logic [YW-1:0] ym_s1;
	logic          v_s2;
	logic          s2_free;
	logic          adv;

	assign s2_free  = !v_s2 || res_ready;
	assign adv      = v_s1 && s2_free;
	assign pk_ready = !v_s1 || s2_free;

	// Stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (pk_ready) v_s1 <= pk_valid;
			if (s2_free)  v_s2 <= v_s1;
		end
	end

	// Stage 1: months since zero
	always_ff @(posedge clk) begin
		if (pk_ready && pk_valid) begin
			status_s1 <= pk_status;
			years_s1  <= pk_years;
			months_s1 <= pk_months;
			days_s1   <= pk_days;
			mask_s1   <= pk_mask;
			ym_s1     <= YW'(32'(pk_years) * MONTHS_PER_YEAR + 32'(pk_months));
		end
	end

	// Stage 2: day count and output register
	always_ff @(posedge clk) begin
		if (adv) begin
			status     <= status_s1;
			years      <= 14'(32'(years_s1));
			months     <= months_s1;
			days       <= days_s1;
			unit_mask  <= mask_s1;
			packed_res <= 22'(32'(ym_s1) * DAYS_PER_MONTH + 32'(days_s1));
		end
	end

	assign res_valid = v_s2;

endmodule

### sv/relative_date_parser.sv
// Relative date parser top level: <n>y<n>m<n>d strings in, one packed result per string out.
// Throughput: one character per cycle unless back-pressure from res_ready stalls the chain; the front
// register, token queue and parse engine each handle one item per cycle when not stalled.
// Path: after its last character is taken, the result of a string passes the front token register,
// the queue write, the parse step into the first packing stage and the second stage as output register.
// Reset: arst_n clears all control and parser state; payload registers are not reset.
module relative_date_parser import rdp_pkg::*; #(
	parameter int unsigned DIGITS_MAX = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [7:0]  ch,
	input  logic        last,
	input  logic        item_valid,
	output logic        item_ready,
	output logic        status,
	output logic [13:0] years,
	output logic [3:0]  months,
	output logic [4:0]  days,
	output logic [2:0]  unit_mask,
	output logic [21:0] packed_res,
	output logic        res_valid,
	input  logic        res_ready
);

	localparam int unsigned AW = digits_to_bits(DIGITS_MAX);

	token_t        f_tok;
	logic          f_valid;
	logic          f_ready;
	token_t        q_tok;
	logic          q_valid;
	logic          q_ready;
	logic          pk_valid;
	logic          pk_ready;
	logic          pk_status;
	logic [AW-1:0] pk_years;
	logic [3:0]    pk_months;
	logic [4:0]    pk_days;
	logic [2:0]    pk_mask;

	rdp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.ch         (ch),
		.last       (last),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.tok        (f_tok),
		.tok_valid  (f_valid),
		.tok_ready  (f_ready)
	);

	rdp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_tok   (f_tok),
		.wr_valid (f_valid),
		.wr_ready (f_ready),
		.rd_tok   (q_tok),
		.rd_valid (q_valid),
		.rd_ready (q_ready)
	);

	rdp_back #(
		.DIGITS_MAX (DIGITS_MAX),
		.AW         (AW)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.tok       (q_tok),
		.tok_valid (q_valid),
		.tok_ready (q_ready),
		.pk_valid  (pk_valid),
		.pk_ready  (pk_ready),
		.pk_status (pk_status),
		.pk_years  (pk_years),
		.pk_months (pk_months),
		.pk_days   (pk_days),
		.pk_mask   (pk_mask)
	);

	rdp_pack #(
		.AW (AW)
	) u_pack (
		.clk        (clk),
		.arst_n     (arst_n),
		.pk_valid   (pk_valid),
		.pk_ready   (pk_ready),
		.pk_status  (pk_status),
		.pk_years   (pk_years),
		.pk_months  (pk_months),
		.pk_days    (pk_days),
		.pk_mask    (pk_mask),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.status     (status),
		.years      (years),
		.months     (months),
		.days       (days),
		.unit_mask  (unit_mask),
		.packed_res (packed_res)
	);

endmodule

### tb/relative_date_parser_checker.sv
// Checker for the relative date parser: tracks every string, predicts its result and compares.
module relative_date_parser_checker import rdp_pkg::*; #(
	parameter int unsigned DIGITS_MAX = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [7:0]  ch,
	input  logic        last,
	input  logic        item_valid,
	input  logic        item_ready,
	input  logic        status,
	input  logic [13:0] years,
	input  logic [3:0]  months,
	input  logic [4:0]  days,
	input  logic [2:0]  unit_mask,
	input  logic [21:0] packed_res,
	input  logic        res_valid,
	input  logic        res_ready,
	output int          fail_count,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	// character that is not a unit
	localparam int unsigned NO_UNIT = 3;

	typedef enum logic { SEEK_NUMBER, IN_NUMBER } scan_phase_t;

	typedef struct {
		logic        status;
		logic [13:0] years;
		logic [3:0]  months;
		logic [4:0]  days;
		logic [2:0]  unit_mask;
		logic [21:0] packed_res;
	} date_result_t;

	date_result_t expected_dates[$];

	// parse state of the string in flight
	scan_phase_t scan_phase   = SEEK_NUMBER;
	int unsigned number_value = 0;
	int unsigned digit_cnt    = 0;
	int unsigned unit_floor   = UNIT_Y;
	int unsigned year_cnt     = 0;
	int unsigned month_cnt    = 0;
	int unsigned day_cnt      = 0;
	logic [2:0]  seen_units   = '0;
	logic        parse_error  = 1'b0;
	int          errors       = 0;

	task automatic clear_parse();
		scan_phase   = SEEK_NUMBER;
		number_value = 0;
		digit_cnt    = 0;
		unit_floor   = UNIT_Y;
		year_cnt     = 0;
		month_cnt    = 0;
		day_cnt      = 0;
		seen_units   = '0;
		parse_error  = 1'b0;
	endtask

	task automatic check_field(input string name, input logic [21:0] want_val,
			input logic [21:0] got_val);
		if (got_val !== want_val) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want_val, got_val);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : scan
		date_result_t want;
		logic unit_done;
		int unsigned letter_unit;
		longint unsigned packed_sum;
		if (!arst_n) begin
			clear_parse();
			expected_dates.delete();
		end else begin
			// compare a finished result with the oldest prediction
			if (res_valid && res_ready) begin
				if (expected_dates.size() == 0) begin
					$display("%0t: unexpected result, status %0d years %0d months %0d days %0d",
						$time, status, years, months, days);
					errors++;
				end else begin
					want = expected_dates.pop_front();
					check_field("status", want.status, status);
					check_field("years", want.years, years);
					check_field("months", want.months, months);
					check_field("days", want.days, days);
					check_field("unit_mask", want.unit_mask, unit_mask);
					check_field("packed_res", want.packed_res, packed_res);
				end
			end

			// advance the parse by one accepted character
			if (item_valid && item_ready) begin
				unit_done = 1'b0;
				if (!parse_error) begin
					if (scan_phase == SEEK_NUMBER) begin
						if ((ch >= CH_TAB && ch <= CH_CR) || ch == CH_SPACE) begin
							// whitespace before a number is skipped
						end else if (ch < CH_ZERO || ch > CH_NINE) begin
							parse_error = 1'b1;
						end else begin
							number_value = ch - CH_ZERO;
							digit_cnt    = 1;
							scan_phase   = IN_NUMBER;
						end
					end else if (ch >= CH_ZERO && ch <= CH_NINE) begin
						if (digit_cnt >= DIGITS_MAX) begin
							parse_error = 1'b1;
						end else begin
							number_value = number_value * 10 + (ch - CH_ZERO);
							digit_cnt++;
						end
					end else begin
						if (ch == CH_Y) letter_unit = UNIT_Y;
						else if (ch == CH_M) letter_unit = UNIT_M;
						else if (ch == CH_D) letter_unit = UNIT_D;
						else letter_unit = NO_UNIT;
						if (letter_unit == NO_UNIT || letter_unit < unit_floor) begin
							parse_error = 1'b1;
						end else begin
							unit_floor = letter_unit;
							if (letter_unit == UNIT_Y) begin
								year_cnt = number_value;
								seen_units[2] = 1'b1;
							end else if (letter_unit == UNIT_M) begin
								if (number_value > MONTH_MAX) parse_error = 1'b1;
								else begin
									month_cnt = number_value;
									seen_units[1] = 1'b1;
								end
							end else begin
								if (number_value > DAY_MAX) parse_error = 1'b1;
								else begin
									day_cnt = number_value;
									seen_units[0] = 1'b1;
								end
							end
							if (!parse_error) begin
								scan_phase   = SEEK_NUMBER;
								number_value = 0;
								digit_cnt    = 0;
								unit_done    = 1'b1;
							end
						end
					end
				end

				// the last character of a string yields its result
				if (last) begin
					if (!parse_error && unit_done) begin
						packed_sum = (longint'(year_cnt) * MONTHS_PER_YEAR + month_cnt)
							* DAYS_PER_MONTH + day_cnt;
						want.status     = 1'b0;
						want.years      = year_cnt[13:0];
						want.months     = month_cnt[3:0];
						want.days       = day_cnt[4:0];
						want.unit_mask  = seen_units;
						want.packed_res = packed_sum[21:0];
					end else begin
						want = '{1'b1, '0, '0, '0, '0, '0};
					end
					expected_dates.push_back(want);
					clear_parse();
				end
			end
		end
		pending    <= expected_dates.size();
		fail_count <= errors;
	end

endmodule

### tb/tb_relative_date_parser.sv
// Testbench top for the relative date parser: reset, clock, character stimulus and verdict.
module tb_relative_date_parser;
	timeunit 1ns;
	timeprecision 1ps;

	import rdp_pkg::*;

	localparam int unsigned MAX_DIGITS   = 4;
	localparam int unsigned RANDOM_ITEMS = 1450;
	localparam int unsigned CYCLE_LIMIT  = 200000;
	localparam int unsigned DRAIN_CYCLES = 16;

	typedef enum {
		MUT_REPLACE,
		MUT_APPEND,
		MUT_DROP_END,
		MUT_EXTRA_DIGIT,
		MUT_NOISE
	} mutation_t;

	logic        clk;
	logic        arst_n;
	logic [7:0]  ch;
	logic        last;
	logic        item_valid;
	logic        item_ready;
	logic        status;
	logic [13:0] years;
	logic [3:0]  months;
	logic [4:0]  days;
	logic [2:0]  unit_mask;
	logic [21:0] packed_res;
	logic        res_valid;
	logic        res_ready;
	int          fail_count;
	int          pending;

	byte unsigned date_text[$];
	int unsigned  chars_sent = 0;
	int unsigned  gap_chance = 4;
	bit           sink_idle  = 1'b1;
	int unsigned  cycle_cnt  = 0;
	string        noise_chars = "0123456789ymdx \t\n\013\f\r";

	relative_date_parser #(.DIGITS_MAX(MAX_DIGITS)) u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.ch         (ch),
		.last       (last),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.status     (status),
		.years      (years),
		.months     (months),
		.days       (days),
		.unit_mask  (unit_mask),
		.packed_res (packed_res),
		.res_valid  (res_valid),
		.res_ready  (res_ready)
	);

	relative_date_parser_checker #(.DIGITS_MAX(MAX_DIGITS)) u_checker (.*);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// result side: stalls in bursts while idling is on
	initial begin : result_sink
		res_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (sink_idle && $urandom_range(0, 5) == 0) begin
				res_ready <= 1'b0;
				repeat ($urandom_range(1, 14)) @(posedge clk);
			end
			res_ready <= 1'b1;
		end
	end

	// watchdog
	initial begin : watchdog
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("[relative_date_parser] ERROR");
		$finish;
	end

	task automatic send_date_char(input logic [7:0] c, input logic is_last);
		if (gap_chance != 0 && $urandom_range(1, gap_chance) == 1) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		ch         <= c;
		last       <= is_last;
		item_valid <= 1'b1;
		@(posedge clk);
		while (!item_ready) @(posedge clk);
		chars_sent++;
	endtask

	task automatic send_string();
		for (int i = 0; i < date_text.size(); i++)
			send_date_char(date_text[i], i == date_text.size() - 1);
	endtask

	task automatic send_text(input string s);
		date_text.delete();
		for (int i = 0; i < s.len(); i++) date_text.push_back(s[i]);
		send_string();
	endtask

	function automatic logic [7:0] pick_space();
		if ($urandom_range(0, 5) == 5) return CH_SPACE;
		return 8'(CH_TAB + $urandom_range(0, 4));
	endfunction

	function automatic logic [7:0] pick_noise();
		if ($urandom_range(0, 1) == 0) return 8'($urandom_range(0, 255));
		return noise_chars[$urandom_range(0, noise_chars.len() - 1)];
	endfunction

	// count for one unit, mostly in range, with the extremes favored
	function automatic int unsigned pick_count(input int unsigned limit, input bit allow_over);
		int unsigned r;
		r = $urandom_range(0, 9);
		if (allow_over && r == 0) return $urandom_range(limit + 1, 99);
		if (r == 1) return limit;
		if (r == 2) return 0;
		return $urandom_range(0, limit);
	endfunction

	// decimal digits, with leading zeros up to the digit limit at random
	task automatic push_number(input int unsigned val);
		int unsigned width;
		int unsigned scale;
		width = 1;
		scale = 1;
		while (val / (scale * 10) != 0) begin
			width++;
			scale *= 10;
		end
		repeat ($urandom_range(width, MAX_DIGITS) - width) date_text.push_back(CH_ZERO);
		while (scale != 0) begin
			date_text.push_back(8'(CH_ZERO + (val / scale) % 10));
			scale /= 10;
		end
	endtask

	// mostly valid string: units in order, some repeated, whitespace before numbers
	task automatic build_date();
		int unsigned unit_at;
		int unsigned segs;
		date_text.delete();
		unit_at = $urandom_range(UNIT_Y, UNIT_D);
		segs = 0;
		while (unit_at <= UNIT_D && segs < 4) begin
			if ($urandom_range(0, 3) == 0)
				repeat ($urandom_range(1, 2)) date_text.push_back(pick_space());
			case (unit_at)
				UNIT_Y: begin
					push_number(pick_count(9999, 1'b0));
					date_text.push_back(CH_Y);
				end
				UNIT_M: begin
					push_number(pick_count(MONTH_MAX, 1'b1));
					date_text.push_back(CH_M);
				end
				default: begin
					push_number(pick_count(DAY_MAX, 1'b1));
					date_text.push_back(CH_D);
				end
			endcase
			if ($urandom_range(0, 5) != 0) unit_at += $urandom_range(1, 2);
			segs++;
		end
	endtask

	// break a string in one of several ways
	task automatic mutate_date();
		int unsigned pos;
		pos = $urandom_range(0, date_text.size() - 1);
		case (mutation_t'($urandom_range(MUT_REPLACE, MUT_NOISE)))
			MUT_REPLACE: date_text[pos] = pick_noise();
			MUT_APPEND: date_text.push_back(pick_noise());
			MUT_DROP_END: if (date_text.size() > 1) void'(date_text.pop_back());
			MUT_EXTRA_DIGIT: date_text.insert(pos, 8'(CH_ZERO + $urandom_range(0, 9)));
			default: begin
				date_text.delete();
				repeat ($urandom_range(1, 6)) date_text.push_back(pick_noise());
			end
		endcase
	endtask

	initial begin : stimulus
		int unsigned random_start;
		ch         <= '0;
		last       <= 1'b0;
		item_valid <= 1'b0;
		arst_n     <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed strings: extremes, repeats and each kind of error
		send_text(" 1y9999y11m30d");
		send_text("y");
		send_text("1 ");
		send_text("12345");
		send_text("1m2y");
		send_text("0y ");
		send_text("1y2");
		send_text("12m");
		send_text("31d");
		date_text.delete();
		date_text.push_back(8'h00);
		send_string();
		date_text.delete();
		date_text.push_back(8'hFF);
		send_string();

		// random strings, mostly well-formed; no idling near the end
		random_start = chars_sent;
		while (chars_sent - random_start < RANDOM_ITEMS) begin
			if (chars_sent - random_start > RANDOM_ITEMS * 17 / 20) begin
				gap_chance = 0;
				sink_idle  = 1'b0;
			end else begin
				case ($urandom_range(0, 2))
					0: gap_chance = 0;
					1: gap_chance = 8;
					default: gap_chance = 3;
				endcase
			end
			build_date();
			if ($urandom_range(0, 3) == 0) mutate_date();
			send_string();
		end
		item_valid <= 1'b0;

		// drain
		repeat (2) @(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("[relative_date_parser] OK");
		else
			$display("[relative_date_parser] ERROR");
		$finish;
	end

endmodule

### relative_date_parser.f
sv/rdp_pkg.sv
sv/rdp_front.sv
sv/rdp_queue.sv
sv/rdp_back.sv
sv/rdp_pack.sv
sv/relative_date_parser.sv
tb/relative_date_parser_checker.sv
tb/tb_relative_date_parser.sv
